FILE: src/gcm_pkg.sv
package gcm_pkg;

  // recipe register layout
  localparam int RECIPE_SLOTS = 5;
  localparam int RECIPE_W     = 15;
  localparam int CODE_W       = 3;
  localparam int LEN_LSB      = 9;
  localparam int ID_LSB       = 11;
  localparam int TIMEOUT_W    = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

  // result queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RECIPE_A = 3'd0,
    REG_RECIPE_B = 3'd1,
    REG_RECIPE_C = 3'd2,
    REG_RECIPE_D = 3'd3,
    REG_RECIPE_E = 3'd4,
    REG_TIMEOUT  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [RECIPE_SLOTS-1:0][RECIPE_W-1:0] recipe;
    logic [TIMEOUT_W-1:0]                  timeout;
  } cfg_t;

  // one released result
  typedef struct packed {
    logic [3:0] combo;
    logic [2:0] cls;
  } res_t;

  // all results caused by one input item
  typedef struct packed {
    logic pair;
    res_t r0;
    res_t r1;
  } entry_t;

  // queue status seen by the front and the back stage
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/gcm_front.sv
module gcm_front import gcm_pkg::*; #(
  parameter int MAX_COMBO_LEN = 3,
  parameter int NUM_RECIPES   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_ms,
  input  logic [2:0]  gesture_code,
  input  q_stat_t     q_stat,
  output logic        push,
  output entry_t      push_entry
);

  localparam int HIW = (MAX_COMBO_LEN > 1) ? $clog2(MAX_COMBO_LEN) : 1;
  localparam logic [1:0] MAX_L = 2'(MAX_COMBO_LEN);

  logic [MAX_COMBO_LEN-1:0][2:0] hist, hist_next;
  logic [1:0]  hlen, hlen_next;
  logic [31:0] last_time, last_time_next;
  logic [3:0]  held, held_next;

  logic        accept;
  logic [31:0] elapsed;
  logic        tmo;
  logic [1:0]  idx;
  logic [2:0]  last_code;
  logic [1:0]  len1, base, n;
  logic [3:0]  held1;
  logic [MAX_COMBO_LEN-1:0][2:0] h2;
  logic        any_prefix, is_full, pre_single;
  logic [3:0]  full_id;
  logic        em_tmo, em_full, em_held, em_single;
  logic [1:0]  cnt;
  res_t [1:0]  res;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // timeout check against the held history
  always_comb begin
    elapsed   = now_ms - last_time;
    tmo       = (hlen != 2'd0) && (elapsed > {16'd0, cfg.timeout});
    idx       = hlen - 2'd1;
    last_code = ((hlen != 2'd0) && (idx < MAX_L)) ? hist[idx[HIW-1:0]] : 3'd0;
    len1      = tmo ? 2'd0 : hlen;
    held1     = tmo ? 4'd0 : held;
    base      = (len1 >= MAX_L) ? 2'd0 : len1;
    n         = base + 2'd1;
    for (int j = 0; j < MAX_COMBO_LEN; j++) begin
      h2[j] = (2'(j) == base) ? gesture_code : hist[j];
    end
  end

  // match the extended history against every enabled recipe
  always_comb begin
    logic [1:0] rlen;
    logic       en;
    logic       same;
    any_prefix = 1'b0;
    is_full    = 1'b0;
    pre_single = 1'b0;
    full_id    = 4'd0;
    for (int r = 0; r < NUM_RECIPES; r++) begin
      rlen = cfg.recipe[r][LEN_LSB +: 2];
      en   = (rlen >= 2'd2) && (rlen <= MAX_L);
      same = 1'b1;
      for (int j = 0; j < MAX_COMBO_LEN; j++) begin
        if ((2'(j) < n) && (cfg.recipe[r][CODE_W*j +: CODE_W] != h2[j])) begin
          same = 1'b0;
        end
      end
      if (en && same && (rlen > n)) begin
        any_prefix = 1'b1;
      end
      if (en && same && (rlen == n)) begin
        is_full = 1'b1;
        full_id = cfg.recipe[r][ID_LSB +: 4];
      end
      // restart test: new code alone as the first code of a recipe
      if (en && (cfg.recipe[r][CODE_W-1:0] == gesture_code)) begin
        pre_single = 1'b1;
      end
    end
  end

  // next state and released results
  always_comb begin
    hist_next      = hist;
    hlen_next      = len1;
    last_time_next = last_time;
    held_next      = held1;
    em_tmo         = tmo;
    em_full        = 1'b0;
    em_held        = 1'b0;
    em_single      = 1'b0;
    if (gesture_code != 3'd0) begin
      hist_next = h2;
      hlen_next = n;
      if (is_full && !any_prefix) begin
        em_full   = 1'b1;
        hlen_next = 2'd0;
        held_next = 4'd0;
      end else if (any_prefix && !is_full) begin
        last_time_next = now_ms;
      end else if (any_prefix && is_full) begin
        held_next      = full_id;
        last_time_next = now_ms;
      end else begin
        // break: release held combo, then single or new prefix
        em_held      = (held1 != 4'd0);
        held_next    = 4'd0;
        hist_next[0] = gesture_code;
        if ((n != 2'd1) && pre_single) begin
          hlen_next      = 2'd1;
          last_time_next = now_ms;
        end else begin
          em_single = 1'b1;
          hlen_next = 2'd0;
        end
      end
    end

    // pack results in order
    res = '0;
    cnt = 2'd0;
    if (em_tmo) begin
      res[cnt[0]] = '{combo: held, cls: last_code};
      cnt = cnt + 2'd1;
    end
    if (em_full) begin
      res[cnt[0]] = '{combo: full_id, cls: 3'd0};
      cnt = cnt + 2'd1;
    end
    if (em_held) begin
      res[cnt[0]] = '{combo: held1, cls: 3'd0};
      cnt = cnt + 2'd1;
    end
    if (em_single) begin
      res[cnt[0]] = '{combo: 4'd0, cls: gesture_code};
      cnt = cnt + 2'd1;
    end
    push       = accept && (cnt != 2'd0);
    push_entry = '{pair: (cnt == 2'd2), r0: res[0], r1: res[1]};
  end

  // matcher state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist      <= '0;
      hlen      <= 2'd0;
      last_time <= 32'd0;
      held      <= 4'd0;
    end else if (accept) begin
      hist      <= hist_next;
      hlen      <= hlen_next;
      last_time <= last_time_next;
      held      <= held_next;
    end
  end

  // a held combo always has history behind it
  a_held_has_hist: assert property (@(posedge clk) disable iff (rst)
    (held != 4'd0) |-> (hlen != 2'd0))
    else $error("held combo without history");

  a_hlen_bound: assert property (@(posedge clk) disable iff (rst)
    hlen <= MAX_L)
    else $error("history length beyond limit");

endmodule

FILE: src/gcm_queue.sv
module gcm_queue import gcm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t stat
);

  entry_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]   wptr, rptr;
  logic [Q_AW:0]     count;
  logic              do_push, do_pop;

  assign stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("push into full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: src/gcm_back.sv
module gcm_back import gcm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] combo_code,
  output logic [2:0] gesture_class,
  output logic       last_of_run
);

  logic pend_valid;
  res_t pend;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_valid && !q_stat.empty;

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid  <= 1'b1;
        pend_valid <= head.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // output beat payload and second result of a pair
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        combo_code    <= pend.combo;
        gesture_class <= pend.cls;
        last_of_run   <= 1'b1;
      end else if (!q_stat.empty) begin
        combo_code    <= head.r0.combo;
        gesture_class <= head.r0.cls;
        last_of_run   <= !head.pair;
        pend          <= head.r1;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (out_valid && !last_of_run))
    else $error("second result waiting without first on output");

endmodule

FILE: src/gesture_combo_matcher.sv
// Gesture combo matcher. Each input beat (now_ms, gesture_code) is matched against up to
// five programmed recipes of two or three codes; released combos and single gestures leave
// as output beats, none, one or two per input, the last flagged by last_of_run. The front stage
// accepts one input beat per cycle while the two-entry result queue has room and classifies
// it in that cycle; the output register sends one result beat per cycle while out_ready is
// high, so an input that releases two results sends them as two beats in order. A result
// is held in a queue entry and then in the output register. Configuration writes are
// taken every cycle and must only be issued while the block is idle.
module gesture_combo_matcher import gcm_pkg::*; #(
  parameter int MAX_COMBO_LEN = 3,
  parameter int NUM_RECIPES   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_ms,
  input  logic [2:0]  gesture_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  combo_code,
  output logic [2:0]  gesture_class,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  q_stat_t q_stat;
  logic    push, pop;
  entry_t  push_entry, head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recipe  <= '0;
      cfg.timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_RECIPE_A: cfg.recipe[0] <= cfg_data[RECIPE_W-1:0];
        REG_RECIPE_B: cfg.recipe[1] <= cfg_data[RECIPE_W-1:0];
        REG_RECIPE_C: cfg.recipe[2] <= cfg_data[RECIPE_W-1:0];
        REG_RECIPE_D: cfg.recipe[3] <= cfg_data[RECIPE_W-1:0];
        REG_RECIPE_E: cfg.recipe[4] <= cfg_data[RECIPE_W-1:0];
        REG_TIMEOUT:  cfg.timeout   <= cfg_data;
        default: ;
      endcase
    end
  end

  gcm_front #(
    .MAX_COMBO_LEN (MAX_COMBO_LEN),
    .NUM_RECIPES   (NUM_RECIPES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .now_ms       (now_ms),
    .gesture_code (gesture_code),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  gcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  gcm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .combo_code    (combo_code),
    .gesture_class (gesture_class),
    .last_of_run   (last_of_run)
  );

endmodule
